@@ rtl/rsk_pkg.sv @@
// Types, command/status words and the name compare for the record sorter.
// Used by rsk_ctrl, rsk_dp and record_sort_by_key_unit.
package rsk_pkg;

  typedef struct packed {
    logic [63:0]        head;
    logic [63:0]        middle;
    logic [31:0]        tail;
    logic signed [15:0] score;
    logic [15:0]        absn;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  localparam logic [1:0] KeyName  = 2'd0;
  localparam logic [1:0] KeyScore = 2'd1;
  localparam logic [1:0] KeyAbsn  = 2'd2;

  // Write data source for the record store
  typedef enum logic [1:0] {
    WSEL_IN = 2'd0,
    WSEL_Q  = 2'd1,
    WSEL_A  = 2'd2,
    WSEL_B  = 2'd3
  } wsel_t;

  typedef struct packed {
    logic  we;
    wsel_t wsel;
    logic  load_a;
    logic  load_b;
    logic  emit;
    logic  emit_last;
    logic  emit_ovf;
  } cmd_t;

  typedef struct packed {
    logic name_gt;   // a sorts after read data by name
    logic score_lt;  // read data score below b score
    logic absn_gt;   // read data absences above b absences
  } sts_t;

  // True when name a sorts strictly after name b; stops at a common zero byte
  function automatic logic name_greater(input rec_t a, input rec_t b);
    logic [159:0] x;
    logic [159:0] y;
    logic         done;
    logic         gt;
    x    = {a.head, a.middle, a.tail};
    y    = {b.head, b.middle, b.tail};
    done = 1'b0;
    gt   = 1'b0;
    for (int k = 0; k < 20; k++) begin
      if (!done) begin
        if (x[159-8*k -: 8] != y[159-8*k -: 8]) begin
          gt   = x[159-8*k -: 8] > y[159-8*k -: 8];
          done = 1'b1;
        end else if (x[159-8*k -: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return gt;
  endfunction

endpackage

@@ rtl/rsk_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rsk_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/rsk_dp.sv @@
// Datapath: record store, two record registers, key compares, result register.
// Depends on rsk_pkg and rsk_ram.
module rsk_dp #(
  parameter int MAX_RECORDS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rsk_pkg::rec_t                  in_rec,
  input  rsk_pkg::cmd_t                  cmd,
  input  logic [$clog2(MAX_RECORDS)-1:0] waddr,
  input  logic [$clog2(MAX_RECORDS)-1:0] raddr,
  output rsk_pkg::sts_t                  sts,
  output rsk_pkg::rec_t                  out_rec,
  output logic                           out_last,
  output logic                           out_ovf,
  output logic                           out_valid
);
  import rsk_pkg::*;

  rec_t q;
  rec_t a_rec;
  rec_t b_rec;
  rec_t wdata;

  // Pick write data
  always_comb begin
    unique case (cmd.wsel)
      WSEL_IN: wdata = in_rec;
      WSEL_Q:  wdata = q;
      WSEL_A:  wdata = a_rec;
      WSEL_B:  wdata = b_rec;
      default: wdata = in_rec;
    endcase
  end

  rsk_ram #(.W(RecW), .D(MAX_RECORDS)) u_store (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  // Compare read data against held records
  always_comb begin
    sts.name_gt  = name_greater(a_rec, q);
    sts.score_lt = q.score < b_rec.score;
    sts.absn_gt  = q.absn > b_rec.absn;
  end

  // Hold records for swaps, minimum and insertion key; capture the result on emit
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_rec <= q;
    end
    if (cmd.load_b) begin
      b_rec <= q;
    end
    if (cmd.emit) begin
      out_rec  <= q;
      out_last <= cmd.emit_last;
      out_ovf  <= cmd.emit_ovf;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end
endmodule

@@ rtl/rsk_ctrl.sv @@
// Controller: load, bubble/selection/insertion sort sequencing and emit.
// Depends on rsk_pkg.
module rsk_ctrl #(
  parameter int MAX_RECORDS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           last_record,
  output logic                           busy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_data,
  input  rsk_pkg::sts_t                  sts,
  output rsk_pkg::cmd_t                  cmd,
  output logic [$clog2(MAX_RECORDS)-1:0] waddr,
  output logic [$clog2(MAX_RECORDS)-1:0] raddr
);
  import rsk_pkg::*;

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MaxC = CW'(MAX_RECORDS);
  localparam logic [CW-1:0] OneC = CW'(1);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_DISP = 16'h0002,
    B_RA   = 16'h0004,
    B_RB   = 16'h0008,
    B_CMP  = 16'h0010,
    B_W2   = 16'h0020,
    L_RI   = 16'h0040,
    L_LI   = 16'h0080,
    L_RJ   = 16'h0100,
    L_CJ   = 16'h0200,
    L_SW1  = 16'h0400,
    L_SW2  = 16'h0800,
    I_RI   = 16'h1000,
    I_RJ   = 16'h2000,
    I_CJ   = 16'h4000,
    E_OUT  = 16'h8000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [1:0]    sort_key;
  logic [IW-1:0] i, i_next, j, j_next, m, m_next;
  logic          ins_put, ins_put_next;
  logic [CW-1:0] i_c, j_c;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign i_c       = CW'(i);
  assign j_c       = CW'(j);

  // Next state and commands
  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    i_next       = i;
    j_next       = j;
    m_next       = m;
    ins_put_next = ins_put;
    cmd          = '0;
    cmd.wsel     = WSEL_IN;
    waddr        = count[IW-1:0];
    raddr        = j;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (count < MaxC) begin
            cmd.we     = 1'b1;
            count_next = count + OneC;
          end else begin
            ovf_next = 1'b1;
          end
          if (last_record) begin
            state_next = S_DISP;
          end
        end
      end
      S_DISP: begin
        i_next = '0;
        j_next = '0;
        if (count < CW'(2)) begin
          state_next = E_OUT;
        end else begin
          unique case (sort_key)
            KeyName:  begin
              i_next     = IW'(1);
              state_next = B_RA;
            end
            KeyScore: state_next = L_RI;
            KeyAbsn:  begin
              i_next     = IW'(1);
              state_next = I_RI;
            end
            default:  state_next = E_OUT;
          endcase
        end
      end
      // Bubble sort by name
      B_RA: begin
        raddr      = j;
        state_next = B_RB;
      end
      B_RB: begin
        raddr      = j + IW'(1);
        cmd.load_a = 1'b1;
        state_next = B_CMP;
      end
      B_CMP: begin
        if (sts.name_gt) begin
          cmd.we     = 1'b1;
          cmd.wsel   = WSEL_Q;
          waddr      = j;
          state_next = B_W2;
        end else begin
          if (j_c + OneC < count - i_c) begin
            j_next     = j + IW'(1);
            state_next = B_RA;
          end else if (i_c + OneC < count) begin
            i_next     = i + IW'(1);
            j_next     = '0;
            state_next = B_RA;
          end else begin
            j_next     = '0;
            state_next = E_OUT;
          end
        end
      end
      B_W2: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_A;
        waddr    = j + IW'(1);
        if (j_c + OneC < count - i_c) begin
          j_next     = j + IW'(1);
          state_next = B_RA;
        end else if (i_c + OneC < count) begin
          i_next     = i + IW'(1);
          j_next     = '0;
          state_next = B_RA;
        end else begin
          j_next     = '0;
          state_next = E_OUT;
        end
      end
      // Selection sort by score
      L_RI: begin
        raddr = i;
        if (i_c + OneC >= count) begin
          j_next     = '0;
          state_next = E_OUT;
        end else begin
          state_next = L_LI;
        end
      end
      L_LI: begin
        cmd.load_b = 1'b1;
        m_next     = i;
        j_next     = i + IW'(1);
        state_next = L_RJ;
      end
      L_RJ: begin
        raddr      = j;
        state_next = L_CJ;
      end
      L_CJ: begin
        if (sts.score_lt) begin
          cmd.load_b = 1'b1;
          m_next     = j;
        end
        if (j_c + OneC < count) begin
          j_next     = j + IW'(1);
          state_next = L_RJ;
        end else begin
          raddr      = i;
          state_next = L_SW1;
        end
      end
      L_SW1: begin
        if (m != i) begin
          cmd.load_a = 1'b1;
          cmd.we     = 1'b1;
          cmd.wsel   = WSEL_B;
          waddr      = i;
          state_next = L_SW2;
        end else begin
          i_next     = i + IW'(1);
          state_next = L_RI;
        end
      end
      L_SW2: begin
        cmd.we     = 1'b1;
        cmd.wsel   = WSEL_A;
        waddr      = m;
        i_next     = i + IW'(1);
        state_next = L_RI;
      end
      // Insertion sort by absences
      I_RI: begin
        raddr        = i;
        j_next       = i - IW'(1);
        ins_put_next = 1'b0;
        state_next   = I_RJ;
      end
      I_RJ: begin
        if (!ins_put) begin
          cmd.load_b = (j == i - IW'(1));
        end
        raddr      = j;
        state_next = I_CJ;
        if (ins_put) begin
          // Key goes to the front
          cmd.we   = 1'b1;
          cmd.wsel = WSEL_B;
          waddr    = '0;
          if (i_c + OneC < count) begin
            i_next     = i + IW'(1);
            state_next = I_RI;
          end else begin
            j_next     = '0;
            state_next = E_OUT;
          end
        end
      end
      I_CJ: begin
        cmd.we = 1'b1;
        waddr  = j + IW'(1);
        if (sts.absn_gt) begin
          cmd.wsel = WSEL_Q;
          if (j == '0) begin
            ins_put_next = 1'b1;
          end else begin
            j_next = j - IW'(1);
          end
          state_next = I_RJ;
        end else begin
          cmd.wsel = WSEL_B;
          if (i_c + OneC < count) begin
            i_next     = i + IW'(1);
            state_next = I_RI;
          end else begin
            j_next     = '0;
            state_next = E_OUT;
          end
        end
      end
      // Emit the words in order: present the address, then capture the read data
      E_OUT: begin
        raddr = j;
        if (ins_put) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (j_c == count - OneC);
          cmd.emit_ovf  = ovf;
          ins_put_next  = 1'b0;
          if (j_c + OneC < count) begin
            j_next = j + IW'(1);
          end else begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_IDLE;
          end
        end else begin
          ins_put_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Reused flag: clear on entering emit
    if (state != E_OUT && state_next == E_OUT) begin
      ins_put_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      sort_key <= KeyName;
      ins_put  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ovf     <= ovf_next;
      ins_put <= ins_put_next;
      if (cfg_valid && cfg_ready) begin
        sort_key <= cfg_data;
      end
    end
  end

  // Loop indexes
  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    m <= m_next;
  end
endmodule

@@ rtl/record_sort_by_key_unit.sv @@
// Record sorter: loads one record a cycle while busy is low. After the last record
// the batch of N is sorted in place (bubble by name, selection by score, insertion
// by absences). Results then come out in sorted order, one-cycle out_valid strobes.
// Synchronous reset empties the batch, clears the overflow flag and selects name key.
// Store contents are not cleared. Depends on rsk_pkg, rsk_ctrl, rsk_dp.
module record_sort_by_key_unit #(
  parameter int MAX_RECORDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] name_head,
  input  logic [63:0] name_middle,
  input  logic [31:0] name_tail,
  input  logic signed [15:0] score_hundredths,
  input  logic [15:0] absences,
  input  logic        last_record,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        out_valid,
  output logic [63:0] out_name_head,
  output logic [63:0] out_name_middle,
  output logic [31:0] out_name_tail,
  output logic signed [15:0] out_score,
  output logic [15:0] out_absences,
  output logic        out_last,
  output logic        overflowed
);
  import rsk_pkg::*;

  localparam int IW = $clog2(MAX_RECORDS);

  cmd_t          cmd;
  sts_t          sts;
  rec_t          in_rec;
  rec_t          out_rec;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;

  // Pack the incoming word
  always_comb begin
    in_rec.head   = name_head;
    in_rec.middle = name_middle;
    in_rec.tail   = name_tail;
    in_rec.score  = score_hundredths;
    in_rec.absn   = absences;
  end

  rsk_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_record (last_record),
    .busy        (busy),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .sts         (sts),
    .cmd         (cmd),
    .waddr       (waddr),
    .raddr       (raddr)
  );

  rsk_dp #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_rec    (in_rec),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr     (raddr),
    .sts       (sts),
    .out_rec   (out_rec),
    .out_last  (out_last),
    .out_ovf   (overflowed),
    .out_valid (out_valid)
  );

  // Unpack the result word
  assign out_name_head   = out_rec.head;
  assign out_name_middle = out_rec.middle;
  assign out_name_tail   = out_rec.tail;
  assign out_score       = out_rec.score;
  assign out_absences    = out_rec.absn;
endmodule
